// ===== src/bsx_pkg.sv =====
// ============================================================================
// bsx_pkg
// Shared types, constants and constant tables of the sRGB to XYZ converter.
// ============================================================================
package bsx_pkg;

   localparam int PIX_W           = 8;
   localparam int OUT_W           = 21;
   localparam int LIN_W           = 25;
   localparam int COEF_W          = 24;
   localparam int PROD_W          = LIN_W + COEF_W;
   localparam int ACC_W           = PROD_W + 1;
   localparam int Q_SHIFT         = 24;
   localparam int DEFAULT_FRAC_BITS = 12;
   localparam int ROM_DEPTH       = 256;

   typedef struct packed {
      logic [PIX_W-1:0] blue;
      logic [PIX_W-1:0] green;
      logic [PIX_W-1:0] red;
      logic [PIX_W-1:0] alpha_in;
   } req_type;

   typedef struct packed {
      logic [OUT_W-1:0] x_val;
      logic [OUT_W-1:0] y_val;
      logic [OUT_W-1:0] z_val;
      logic [PIX_W-1:0] alpha_out;
   } rsp_type;

   // Linear channels in Q24, index 0 is red, 1 is green, 2 is blue.
   typedef struct packed {
      logic [2:0][LIN_W-1:0] lin;
      logic [PIX_W-1:0]      alpha;
   } lin_type;

   typedef struct packed {
      logic [2:0][2:0][PROD_W-1:0] prod;
      logic [PIX_W-1:0]            alpha;
   } prod_type;

   // Row sums in Q48, index 0 is X, 1 is Y, 2 is Z.
   typedef struct packed {
      logic [2:0][ACC_W-1:0] acc;
      logic [PIX_W-1:0]      alpha;
   } acc_type;

   typedef logic [ROM_DEPTH-1:0][LIN_W-1:0] lin_rom_type;
   typedef logic [2:0][2:0][COEF_W-1:0]     coef_mat_type;

   function automatic logic [COEF_W-1:0] coef_q24(input logic [63:0] n);
      logic [63:0] q;
      begin
         q = ((n << Q_SHIFT) + 64'd5000000) / 64'd10000000;
         coef_q24 = q[COEF_W-1:0];
      end
   endfunction

   function automatic coef_mat_type build_coef();
      coef_mat_type m;
      begin
         m[0][0] = coef_q24(64'd4124564);
         m[0][1] = coef_q24(64'd3575761);
         m[0][2] = coef_q24(64'd1804375);
         m[1][0] = coef_q24(64'd2126729);
         m[1][1] = coef_q24(64'd7151522);
         m[1][2] = coef_q24(64'd721750);
         m[2][0] = coef_q24(64'd193339);
         m[2][1] = coef_q24(64'd1191920);
         m[2][2] = coef_q24(64'd9503041);
         build_coef = m;
      end
   endfunction

   // The sRGB decode curve, evaluated at elaboration: the power segment finds
   // t^0.4 as the largest r whose fifth power stays at or below t squared.
   function automatic lin_rom_type build_lin_rom();
      lin_rom_type rom;
      logic [63:0] v;
      logic [63:0] a;
      logic [63:0] t;
      logic [63:0] t2;
      logic [63:0] lo;
      logic [63:0] hi;
      logic [63:0] mid;
      logic [63:0] p;
      logic [63:0] e;
      int          i;
      int          k;
      int          n;
      begin
         for (i = 0; i < ROM_DEPTH; i++) begin
            v = 64'(i);
            if (v <= 64'd10) begin
               e = (((v * 64'd100) << Q_SHIFT) + 64'd164730) / 64'd329460;
            end else begin
               a  = 64'd1000 * v + 64'd14025;
               t  = ((a << Q_SHIFT) + 64'd134512) / 64'd269025;
               t2 = (t * t + (64'd1 << (Q_SHIFT - 1))) >> Q_SHIFT;
               lo = 64'd0;
               hi = 64'd1 << Q_SHIFT;
               for (n = 0; n < Q_SHIFT + 2; n++) begin
                  if (lo < hi) begin
                     mid = (lo + hi + 64'd1) >> 1;
                     p   = mid;
                     for (k = 0; k < 4; k++) begin
                        p = (p * mid) >> Q_SHIFT;
                     end
                     if (p <= t2) begin
                        lo = mid;
                     end else begin
                        hi = mid - 64'd1;
                     end
                  end
               end
               e = (t2 * lo + (64'd1 << (Q_SHIFT - 1))) >> Q_SHIFT;
            end
            rom[i] = e[LIN_W-1:0];
         end
         build_lin_rom = rom;
      end
   endfunction

   localparam lin_rom_type  LIN_ROM = build_lin_rom();
   localparam coef_mat_type COEF    = build_coef();

endpackage

// ===== src/bsx_decode.sv =====
// ============================================================================
// bsx_decode
// Input register and sRGB decode table lookup, two pipeline stages.
// ============================================================================
module bsx_decode
   import bsx_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   input  req_type in_pixel,
   output logic    in_stall,
   output logic    out_valid,
   output lin_type out_lin,
   input  logic    out_stall
);

   logic    pix_valid_ff;
   req_type pix_ff;
   logic    lin_valid_ff;
   lin_type lin_ff;
   lin_type lin_in;
   logic    adv_pix;
   logic    adv_lin;

   assign adv_lin = !lin_valid_ff || !out_stall;
   assign adv_pix = !pix_valid_ff || adv_lin;

   always_comb begin
      lin_in.lin[0] = LIN_ROM[pix_ff.red];
      lin_in.lin[1] = LIN_ROM[pix_ff.green];
      lin_in.lin[2] = LIN_ROM[pix_ff.blue];
      lin_in.alpha  = pix_ff.alpha_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pix_valid_ff <= 1'b0;
         lin_valid_ff <= 1'b0;
      end else begin
         if (adv_pix) begin
            pix_valid_ff <= in_valid;
         end
         if (adv_lin) begin
            lin_valid_ff <= pix_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv_pix && in_valid) begin
         pix_ff <= in_pixel;
      end
      if (adv_lin && pix_valid_ff) begin
         lin_ff <= lin_in;
      end
   end

   assign in_stall  = !adv_pix;
   assign out_valid = lin_valid_ff;
   assign out_lin   = lin_ff;

endmodule

// ===== src/bsx_matrix.sv =====
// ============================================================================
// bsx_matrix
// RGB to XYZ matrix: registered products, then registered row sums.
// ============================================================================
module bsx_matrix
   import bsx_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   input  lin_type in_lin,
   output logic    in_stall,
   output logic    out_valid,
   output acc_type out_acc,
   input  logic    out_stall
);

   logic     prod_valid_ff;
   prod_type prod_ff;
   prod_type prod_in;
   logic     acc_valid_ff;
   acc_type  acc_ff;
   acc_type  acc_in;
   logic     adv_prod;
   logic     adv_acc;

   assign adv_acc  = !acc_valid_ff || !out_stall;
   assign adv_prod = !prod_valid_ff || adv_acc;

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            prod_in.prod[r][c] = PROD_W'(in_lin.lin[c]) * PROD_W'(COEF[r][c]);
         end
      end
      prod_in.alpha = in_lin.alpha;
   end

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         acc_in.acc[r] = ACC_W'(prod_ff.prod[r][0]) + ACC_W'(prod_ff.prod[r][1])
                       + ACC_W'(prod_ff.prod[r][2]);
      end
      acc_in.alpha = prod_ff.alpha;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         acc_valid_ff  <= 1'b0;
      end else begin
         if (adv_prod) begin
            prod_valid_ff <= in_valid;
         end
         if (adv_acc) begin
            acc_valid_ff <= prod_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv_prod && in_valid) begin
         prod_ff <= prod_in;
      end
      if (adv_acc && prod_valid_ff) begin
         acc_ff <= acc_in;
      end
   end

   assign in_stall  = !adv_prod;
   assign out_valid = acc_valid_ff;
   assign out_acc   = acc_ff;

endmodule

// ===== src/bsx_scale.sv =====
// ============================================================================
// bsx_scale
// Scales each row sum by 255, rounds to the output format and saturates.
// ============================================================================
module bsx_scale
   import bsx_pkg::*;
#(
   parameter int FRAC_BITS = DEFAULT_FRAC_BITS
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   input  acc_type in_acc,
   output logic    in_stall,
   output logic    out_valid,
   output rsp_type out_rsp,
   input  logic    out_stall
);

   localparam int SC_W      = ACC_W + 8;
   localparam int SHIFT     = 2 * Q_SHIFT - FRAC_BITS;
   localparam logic [SC_W-1:0] ROUND_ADD = SC_W'(1) << (SHIFT - 1);

   logic                   rsp_valid_ff;
   rsp_type                rsp_ff;
   rsp_type                rsp_in;
   logic                   adv_rsp;
   logic [2:0][OUT_W-1:0]  val;

   assign adv_rsp = !rsp_valid_ff || !out_stall;

   always_comb begin
      logic [SC_W-1:0] scaled;
      logic [SC_W-1:0] shifted;
      for (int r = 0; r < 3; r++) begin
         scaled  = {in_acc.acc[r], 8'd0} - SC_W'(in_acc.acc[r]) + ROUND_ADD;
         shifted = scaled >> SHIFT;
         if (|shifted[SC_W-1:OUT_W]) begin
            val[r] = '1;
         end else begin
            val[r] = shifted[OUT_W-1:0];
         end
      end
      rsp_in.x_val     = val[0];
      rsp_in.y_val     = val[1];
      rsp_in.z_val     = val[2];
      rsp_in.alpha_out = in_acc.alpha;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv_rsp) begin
         rsp_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv_rsp && in_valid) begin
         rsp_ff <= rsp_in;
      end
   end

   assign in_stall  = !adv_rsp;
   assign out_valid = rsp_valid_ff;
   assign out_rsp   = rsp_ff;

endmodule

// ===== src/bgra_srgb_to_xyz_converter.sv =====
// ============================================================================
// bgra_srgb_to_xyz_converter
// Throughput: one item per cycle while rsp_stall is low; five register stages
// (input, decode table, products, row sums, scaled output) each hold one item,
// and an accepted item passes through all five before it appears on rsp_valid.
// Reset: synchronous, clears all stage valid bits; no table clearing is needed.
// Converts one sRGB BGRA pixel to D65 XYZ scaled by 255, alpha passed through.
// ============================================================================
module bgra_srgb_to_xyz_converter
   import bsx_pkg::*;
#(
   parameter int FRAC_BITS = DEFAULT_FRAC_BITS
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  req_type req_data,
   output logic    req_stall,
   output logic    rsp_valid,
   output rsp_type rsp_data,
   input  logic    rsp_stall
);

   logic    lin_valid;
   lin_type lin_data;
   logic    lin_stall;
   logic    acc_valid;
   acc_type acc_data;
   logic    acc_stall;

   bsx_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_pixel  (req_data),
      .in_stall  (req_stall),
      .out_valid (lin_valid),
      .out_lin   (lin_data),
      .out_stall (lin_stall)
   );

   bsx_matrix u_matrix (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (lin_valid),
      .in_lin    (lin_data),
      .in_stall  (lin_stall),
      .out_valid (acc_valid),
      .out_acc   (acc_data),
      .out_stall (acc_stall)
   );

   bsx_scale #(
      .FRAC_BITS (FRAC_BITS)
   ) u_scale (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (acc_valid),
      .in_acc    (acc_data),
      .in_stall  (acc_stall),
      .out_valid (rsp_valid),
      .out_rsp   (rsp_data),
      .out_stall (rsp_stall)
   );

endmodule

// ===== tb/sv/bgra_srgb_to_xyz_converter_tb.sv =====
// ============================================================================
// bgra_srgb_to_xyz_converter_tb
// Self-checking testbench of the BGRA sRGB to XYZ converter. Each accepted
// pixel is converted by a local model of the sRGB decode curve and the D65
// matrix, and every result item is compared field by field, in order, with
// the oldest prediction. Directed pixels, random pixels, a long output hold
// that fills the pipeline, and an idle-free stream are run in turn.
// ============================================================================
module bgra_srgb_to_xyz_converter_tb
   import bsx_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int          FRAC_BITS = DEFAULT_FRAC_BITS;
   localparam logic [63:0] OUT_LIMIT = (64'd1 << OUT_W) - 64'd1;

   logic    clock = 1'b0;
   logic    reset;
   logic    req_valid;
   req_type req_data;
   logic    req_stall;
   logic    rsp_valid;
   rsp_type rsp_data;
   logic    rsp_stall;

   logic [63:0] srgb_linear_q24 [256];
   logic [63:0] xyz_coef_q24 [3][3];
   rsp_type     xyz_expected_q [$];
   int unsigned mismatch_count = 0;
   bit          req_idle_en = 1'b1;
   bit          rsp_idle_en = 1'b1;
   int unsigned rsp_hold_cycles = 0;

   bgra_srgb_to_xyz_converter #(
      .FRAC_BITS(FRAC_BITS)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_data (req_data),
      .req_stall(req_stall),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data),
      .rsp_stall(rsp_stall)
   );

   always begin
      #5ns clock = 1'b1;
      #5ns clock = 1'b0;
   end

   function automatic logic [63:0] q24_from_e7(input logic [63:0] n);
      q24_from_e7 = ((n << 24) + 64'd5000000) / 64'd10000000;
   endfunction

   initial begin : build_tables
      logic [63:0] a;
      logic [63:0] t;
      logic [63:0] t2;
      logic [63:0] lo;
      logic [63:0] hi;
      logic [63:0] mid;
      logic [63:0] p;
      for (int v = 0; v < 256; v++) begin
         if (v <= 10) begin
            srgb_linear_q24[v] = (((64'(v) * 64'd100) << 24) + 64'd164730) / 64'd329460;
         end else begin
            a  = 64'd1000 * 64'(v) + 64'd14025;
            t  = ((a << 24) + 64'd134512) / 64'd269025;
            t2 = (t * t + (64'd1 << 23)) >> 24;
            lo = 64'd0;
            hi = 64'd1 << 24;
            while (lo < hi) begin
               mid = (lo + hi + 64'd1) >> 1;
               p   = mid;
               repeat (4) p = (p * mid) >> 24;
               if (p <= t2) begin
                  lo = mid;
               end else begin
                  hi = mid - 64'd1;
               end
            end
            srgb_linear_q24[v] = (t2 * lo + (64'd1 << 23)) >> 24;
         end
      end
      xyz_coef_q24[0][0] = q24_from_e7(64'd4124564);
      xyz_coef_q24[0][1] = q24_from_e7(64'd3575761);
      xyz_coef_q24[0][2] = q24_from_e7(64'd1804375);
      xyz_coef_q24[1][0] = q24_from_e7(64'd2126729);
      xyz_coef_q24[1][1] = q24_from_e7(64'd7151522);
      xyz_coef_q24[1][2] = q24_from_e7(64'd721750);
      xyz_coef_q24[2][0] = q24_from_e7(64'd193339);
      xyz_coef_q24[2][1] = q24_from_e7(64'd1191920);
      xyz_coef_q24[2][2] = q24_from_e7(64'd9503041);
   end

   function automatic rsp_type predict_xyz(input req_type px);
      rsp_type     r;
      logic [63:0] lin [3];
      logic [63:0] xyz [3];
      logic [63:0] acc;
      lin[0] = srgb_linear_q24[px.red];
      lin[1] = srgb_linear_q24[px.green];
      lin[2] = srgb_linear_q24[px.blue];
      for (int k = 0; k < 3; k++) begin
         acc = xyz_coef_q24[k][0] * lin[0] + xyz_coef_q24[k][1] * lin[1]
             + xyz_coef_q24[k][2] * lin[2];
         xyz[k] = (64'd255 * acc + (64'd1 << (47 - FRAC_BITS))) >> (48 - FRAC_BITS);
         if (xyz[k] > OUT_LIMIT) begin
            xyz[k] = OUT_LIMIT;
         end
      end
      r.x_val     = xyz[0][OUT_W-1:0];
      r.y_val     = xyz[1][OUT_W-1:0];
      r.z_val     = xyz[2][OUT_W-1:0];
      r.alpha_out = px.alpha_in;
      predict_xyz = r;
   endfunction

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      $display("%0t: mismatch: %s", $time, msg);
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            xyz_expected_q.push_back(predict_xyz(req_data));
         end
         if (rsp_valid && !rsp_stall) begin
            if (xyz_expected_q.size() == 0) begin
               report_mismatch($sformatf("result item with no pixel pending: %h", rsp_data));
            end else begin
               want = xyz_expected_q.pop_front();
               if (rsp_data.x_val !== want.x_val) begin
                  report_mismatch($sformatf("x_val got %0d expected %0d",
                                            rsp_data.x_val, want.x_val));
               end
               if (rsp_data.y_val !== want.y_val) begin
                  report_mismatch($sformatf("y_val got %0d expected %0d",
                                            rsp_data.y_val, want.y_val));
               end
               if (rsp_data.z_val !== want.z_val) begin
                  report_mismatch($sformatf("z_val got %0d expected %0d",
                                            rsp_data.z_val, want.z_val));
               end
               if (rsp_data.alpha_out !== want.alpha_out) begin
                  report_mismatch($sformatf("alpha_out got %0d expected %0d",
                                            rsp_data.alpha_out, want.alpha_out));
               end
            end
         end
      end
   end

   initial begin : drive_rsp_stall
      int unsigned span;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_cycles != 0) begin
            span            = rsp_hold_cycles;
            rsp_hold_cycles = 0;
            rsp_stall <= 1'b1;
            repeat (span) @(negedge clock);
            rsp_stall <= 1'b0;
         end else if (rsp_idle_en && $urandom_range(0, 4) == 0) begin
            span = $urandom_range(1, 11);
            rsp_stall <= 1'b1;
            repeat (span) @(negedge clock);
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic send_pixel(input req_type px);
      int unsigned gap;
      @(negedge clock);
      if (req_idle_en && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 11);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= px;
      do @(posedge clock); while (req_stall);
   endtask

   // Favors the linear segment of the decode curve and the channel extremes.
   function automatic logic [7:0] random_level();
      case ($urandom_range(0, 7))
         0:       random_level = 8'($urandom_range(0, 12));
         1:       random_level = $urandom_range(0, 1) ? 8'hFF : 8'h00;
         default: random_level = 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic req_type random_pixel();
      req_type px;
      px.blue     = random_level();
      px.green    = random_level();
      px.red      = random_level();
      px.alpha_in = 8'($urandom_range(0, 255));
      random_pixel = px;
   endfunction

   task automatic test_directed_pixels();
      send_pixel(req_type'{8'h00, 8'h00, 8'h00, 8'h00});
      send_pixel(req_type'{8'hFF, 8'hFF, 8'hFF, 8'hFF});
      send_pixel(req_type'{8'h00, 8'h00, 8'hFF, 8'h80});
      send_pixel(req_type'{8'h00, 8'hFF, 8'h00, 8'h01});
      send_pixel(req_type'{8'hFF, 8'h00, 8'h00, 8'hFE});
      send_pixel(req_type'{8'h01, 8'h01, 8'h01, 8'h7F});
      send_pixel(req_type'{8'h0A, 8'h0A, 8'h0A, 8'h01});
      send_pixel(req_type'{8'h0B, 8'h0B, 8'h0B, 8'hFE});
      send_pixel(req_type'{8'h0A, 8'h0B, 8'h0C, 8'h3C});
      send_pixel(req_type'{8'h0B, 8'h0A, 8'hFF, 8'h11});
      send_pixel(req_type'{8'hAA, 8'h55, 8'hAA, 8'h55});
      send_pixel(req_type'{8'h55, 8'hAA, 8'h55, 8'hAA});
      send_pixel(req_type'{8'hFF, 8'hFF, 8'h00, 8'h00});
      send_pixel(req_type'{8'h00, 8'hFF, 8'hFF, 8'hFF});
      send_pixel(req_type'{8'hFF, 8'h00, 8'hFF, 8'h40});
      send_pixel(req_type'{8'h80, 8'h80, 8'h80, 8'hC3});
      send_pixel(req_type'{8'hFE, 8'h02, 8'h7F, 8'h00});
   endtask

   task automatic test_random_pixels();
      req_idle_en = 1'b1;
      rsp_idle_en = 1'b1;
      repeat (950) send_pixel(random_pixel());
   endtask

   task automatic test_backpressure_fill();
      req_idle_en     = 1'b0;
      rsp_idle_en     = 1'b0;
      rsp_hold_cycles = 80;
      repeat (60) send_pixel(random_pixel());
   endtask

   task automatic test_streaming_tail();
      req_idle_en = 1'b0;
      rsp_idle_en = 1'b0;
      repeat (420) send_pixel(random_pixel());
   endtask

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed_pixels();
      test_random_pixels();
      test_backpressure_fill();
      test_streaming_tail();
      @(negedge clock);
      req_valid <= 1'b0;
      while (xyz_expected_q.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && xyz_expected_q.size() == 0) begin
         $display("bgra_srgb_to_xyz_converter_tb: PASS");
      end else begin
         $display("bgra_srgb_to_xyz_converter_tb: FAIL");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("bgra_srgb_to_xyz_converter_tb: FAIL");
      $finish;
   end

endmodule

// ===== filelist.f =====
src/bsx_pkg.sv
src/bsx_decode.sv
src/bsx_matrix.sv
src/bsx_scale.sv
src/bgra_srgb_to_xyz_converter.sv
tb/sv/bgra_srgb_to_xyz_converter_tb.sv
